FILE: design/sexp_pkg.sv
package sexp_pkg;

  // Lexer modes; codes that mean nothing act as idle.
  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_TOKEN  = 3'd1,
    MODE_STRING = 3'd2,
    MODE_LINE   = 3'd3,
    MODE_SLASH  = 3'd4,
    MODE_BLOCK  = 3'd5
  } mode_e;

  // Token types carried on the word that closes a token.
  typedef enum logic [2:0] {
    TOK_SYMBOL = 3'd0,
    TOK_NUMBER = 3'd1,
    TOK_STRING = 3'd2,
    TOK_LPAREN = 3'd3,
    TOK_RPAREN = 3'd4,
    TOK_END    = 3'd5
  } tok_e;

  // Number shape while a token is open.
  localparam logic [1:0] SHAPE_NONE  = 2'd0;
  localparam logic [1:0] SHAPE_MINUS = 2'd1;
  localparam logic [1:0] SHAPE_DOT   = 2'd2;
  localparam logic [1:0] SHAPE_NUM   = 2'd3;

  // Character codes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_UC_A   = 8'h41;
  localparam logic [7:0] CH_UC_Z   = 8'h5A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LC_A   = 8'h61;
  localparam logic [7:0] CH_LC_Z   = 8'h7A;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        token_end;
    tok_e        token_type;
    logic [15:0] start_line;
    logic [15:0] start_column;
    logic        last_result;
  } res_t;

  // Results of one accepted item, handed from the lexer core to the queue.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic logic is_tok(input logic [7:0] b);
    return is_digit(b) || ((b >= CH_LC_A) && (b <= CH_LC_Z)) ||
           ((b >= CH_UC_A) && (b <= CH_UC_Z)) ||
           (b == CH_MINUS) || (b == CH_DOT) || (b == CH_UNDER);
  endfunction

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) ||
           (b == CH_VT) || (b == CH_FF);
  endfunction

  // Build a result word; the byte and the type read as zero when not flagged.
  function automatic res_t mk_res(input logic [7:0] b, input logic valid,
                                  input logic tend, input tok_e ttype,
                                  input logic [15:0] ln, input logic [15:0] cl);
    res_t r;
    r.out_byte     = valid ? b : 8'h00;
    r.byte_valid   = valid;
    r.token_end    = tend;
    r.token_type   = tend ? ttype : TOK_SYMBOL;
    r.start_line   = ln;
    r.start_column = cl;
    r.last_result  = 1'b0;
    return r;
  endfunction

endpackage

FILE: design/s_expression_char_lexer.sv
// With the result queue empty, a word's first result appears at the output in the
// cycle after the word is accepted; queued results ahead of it leave first.
// The block accepts one input word per cycle while the input is not stalled; a word
// may yield two results, and the four-entry result queue absorbs the difference.
// The input stalls while more than two results are queued.
// Reset (rst_ni low, asynchronous): idle between tokens, line 1, column 1, queue empty.
module s_expression_char_lexer #(
  parameter int POSITION_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          text_byte_i,
  input  logic                end_mark_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                byte_valid_o,
  output logic                token_end_o,
  output logic [2:0]          token_type_o,
  output logic [15:0]         start_line_o,
  output logic [15:0]         start_column_o,
  output logic                last_result_o
);
  import sexp_pkg::*;

  logic  in_acc;
  logic  out_pop;
  logic  full;
  push_t push;
  res_t  head;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_pop = out_valid_o && !out_stall_i;
  assign in_stall_o = full;

  // Lexer state and per-word result generation.
  sexp_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (in_acc),
    .text_byte_i(text_byte_i),
    .end_mark_i (end_mark_i),
    .push_o     (push)
  );

  // Result queue between the lexer and the output channel.
  sexp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (out_pop),
    .full_o (full),
    .valid_o(out_valid_o),
    .head_o (head)
  );

  assign out_byte_o     = head.out_byte;
  assign byte_valid_o   = head.byte_valid;
  assign token_end_o    = head.token_end;
  assign token_type_o   = head.token_type;
  assign start_line_o   = head.start_line;
  assign start_column_o = head.start_column;
  assign last_result_o  = head.last_result;

`ifndef SYNTHESIS
  // The input only stalls while results are waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with no results queued");

  // An end mark always produces a result on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && end_mark_i) |=> out_valid_o)
    else $error("end mark produced no result");

  // A word without a token byte always closes a token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> token_end_o)
    else $error("empty result word does not close a token");

  // With two results, only the second one closes the item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.cnt == 2'd2) |-> (!push.r0.last_result && push.r1.last_result))
    else $error("last flag misplaced on a two-result item");
`endif

endmodule

FILE: design/sexp_core.sv
module sexp_core #(
  parameter int POSITION_BITS = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_i,
  input  logic [7:0]     text_byte_i,
  input  logic           end_mark_i,
  output sexp_pkg::push_t push_o
);
  import sexp_pkg::*;

  localparam int CW = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  // Saturate a position to the 16-bit output field.
  function automatic logic [15:0] cap16(input logic [POSITION_BITS-1:0] v);
    logic [CW-1:0] ext;
    ext = CW'(v);
    return (ext > CW'(16'hFFFF)) ? 16'hFFFF : ext[15:0];
  endfunction

  mode_e                    mode_q, mode_d;
  logic                     quote_q, quote_d;
  logic                     star_q, star_d;
  logic [1:0]               shape_q, shape_d;
  logic [POSITION_BITS-1:0] cur_line_q, cur_line_d;
  logic [POSITION_BITS-1:0] cur_col_q, cur_col_d;
  logic [POSITION_BITS-1:0] tok_line_q, tok_line_d;
  logic [POSITION_BITS-1:0] tok_col_q, tok_col_d;

  // Handling of a byte that may start a new token.
  mode_e      sb_mode;
  logic       sb_tok_set;
  logic       sb_quote;
  logic [1:0] sb_shape;
  logic       sb_emit;
  res_t       sb_res;

  always_comb begin
    sb_mode    = MODE_IDLE;
    sb_tok_set = 1'b0;
    sb_quote   = quote_q;
    sb_shape   = shape_q;
    sb_emit    = 1'b0;
    sb_res     = '0;
    if (is_space(text_byte_i)) begin
      sb_mode = MODE_IDLE;
    end else if ((text_byte_i == CH_SEMI) || (text_byte_i == CH_HASH)) begin
      sb_mode = MODE_LINE;
    end else if (text_byte_i == CH_SLASH) begin
      sb_mode = MODE_SLASH;
    end else begin
      sb_tok_set = 1'b1;
      if ((text_byte_i == CH_DQUOTE) || (text_byte_i == CH_SQUOTE)) begin
        sb_mode  = MODE_STRING;
        sb_quote = (text_byte_i == CH_SQUOTE);
      end else if (text_byte_i == CH_LPAREN) begin
        sb_emit = 1'b1;
        sb_res  = mk_res(text_byte_i, 1'b1, 1'b1, TOK_LPAREN,
                         cap16(cur_line_q), cap16(cur_col_q));
      end else if (text_byte_i == CH_RPAREN) begin
        sb_emit = 1'b1;
        sb_res  = mk_res(text_byte_i, 1'b1, 1'b1, TOK_RPAREN,
                         cap16(cur_line_q), cap16(cur_col_q));
      end else if (is_tok(text_byte_i)) begin
        sb_mode  = MODE_TOKEN;
        sb_emit  = 1'b1;
        sb_shape = is_digit(text_byte_i)      ? SHAPE_NUM :
                   (text_byte_i == CH_MINUS)  ? SHAPE_MINUS :
                   (text_byte_i == CH_DOT)    ? SHAPE_DOT : SHAPE_NONE;
        sb_res   = mk_res(text_byte_i, 1'b1, 1'b0, TOK_SYMBOL,
                          cap16(cur_line_q), cap16(cur_col_q));
      end else begin
        sb_emit = 1'b1;
        sb_res  = mk_res(text_byte_i, 1'b1, 1'b1, TOK_SYMBOL,
                         cap16(cur_line_q), cap16(cur_col_q));
      end
    end
  end

  // Main step: next state and up to two result words.
  tok_e close_type;
  logic use_sb;
  logic sb_slot1;
  res_t r0, r1;
  logic [1:0] cnt;
  logic [7:0] quote_char;

  assign close_type = (shape_q == SHAPE_NUM) ? TOK_NUMBER : TOK_SYMBOL;
  assign quote_char = quote_q ? CH_SQUOTE : CH_DQUOTE;

  always_comb begin
    mode_d     = mode_q;
    quote_d    = quote_q;
    star_d     = star_q;
    shape_d    = shape_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    r0         = '0;
    r1         = '0;
    cnt        = 2'd0;
    use_sb     = 1'b0;
    sb_slot1   = 1'b0;
    if (acc_i) begin
      if (end_mark_i) begin
        // Close any open token, emit the end token, then restart.
        if ((mode_q == MODE_TOKEN) || (mode_q == MODE_STRING)) begin
          r0  = mk_res(8'h00, 1'b0, 1'b1,
                       (mode_q == MODE_TOKEN) ? close_type : TOK_STRING,
                       cap16(tok_line_q), cap16(tok_col_q));
          r1  = mk_res(8'h00, 1'b0, 1'b1, TOK_END,
                       cap16(cur_line_q), cap16(cur_col_q));
          cnt = 2'd2;
        end else begin
          r0  = mk_res(8'h00, 1'b0, 1'b1, TOK_END,
                       cap16(cur_line_q), cap16(cur_col_q));
          cnt = 2'd1;
        end
        mode_d     = MODE_IDLE;
        quote_d    = 1'b0;
        star_d     = 1'b0;
        shape_d    = SHAPE_NONE;
        cur_line_d = POS_ONE;
        cur_col_d  = POS_ONE;
        tok_line_d = POS_ONE;
        tok_col_d  = POS_ONE;
      end else if ((text_byte_i != CH_CR) && (text_byte_i != CH_NUL)) begin
        // Position advance with saturation.
        if (text_byte_i == CH_LF) begin
          if (cur_line_q != POS_MAX) cur_line_d = cur_line_q + POS_ONE;
          cur_col_d = POS_ONE;
        end else if (cur_col_q != POS_MAX) begin
          cur_col_d = cur_col_q + POS_ONE;
        end
        unique case (mode_q)
          MODE_TOKEN: begin
            if (is_tok(text_byte_i)) begin
              if (shape_q == SHAPE_MINUS) begin
                shape_d = is_digit(text_byte_i)     ? SHAPE_NUM :
                          (text_byte_i == CH_DOT)   ? SHAPE_DOT : SHAPE_NONE;
              end else if (shape_q == SHAPE_DOT) begin
                shape_d = is_digit(text_byte_i) ? SHAPE_NUM : SHAPE_NONE;
              end
              r0  = mk_res(text_byte_i, 1'b1, 1'b0, TOK_SYMBOL,
                           cap16(tok_line_q), cap16(tok_col_q));
              cnt = 2'd1;
            end else begin
              r0       = mk_res(8'h00, 1'b0, 1'b1, close_type,
                                cap16(tok_line_q), cap16(tok_col_q));
              cnt      = 2'd1;
              use_sb   = 1'b1;
              sb_slot1 = 1'b1;
            end
          end
          MODE_STRING: begin
            if (text_byte_i == quote_char) begin
              r0     = mk_res(8'h00, 1'b0, 1'b1, TOK_STRING,
                              cap16(tok_line_q), cap16(tok_col_q));
              mode_d = MODE_IDLE;
            end else begin
              r0 = mk_res(text_byte_i, 1'b1, 1'b0, TOK_SYMBOL,
                          cap16(tok_line_q), cap16(tok_col_q));
            end
            cnt = 2'd1;
          end
          MODE_LINE: begin
            if (text_byte_i == CH_LF) mode_d = MODE_IDLE;
          end
          MODE_SLASH: begin
            if (text_byte_i == CH_SLASH) begin
              mode_d = MODE_LINE;
            end else if (text_byte_i == CH_STAR) begin
              mode_d = MODE_BLOCK;
              star_d = 1'b0;
            end else begin
              use_sb = 1'b1;
            end
          end
          MODE_BLOCK: begin
            if ((text_byte_i == CH_SLASH) && star_q) begin
              mode_d = MODE_IDLE;
              star_d = 1'b0;
            end else begin
              star_d = (text_byte_i == CH_STAR);
            end
          end
          default: begin
            use_sb = 1'b1;
          end
        endcase
        // Apply the token-start handling where the byte begins something new.
        if (use_sb) begin
          mode_d  = sb_mode;
          quote_d = sb_quote;
          shape_d = sb_shape;
          if (sb_tok_set) begin
            tok_line_d = cur_line_q;
            tok_col_d  = cur_col_q;
          end
          if (sb_emit) begin
            if (sb_slot1) begin
              r1  = sb_res;
              cnt = 2'd2;
            end else begin
              r0  = sb_res;
              cnt = 2'd1;
            end
          end
        end
      end
    end
    // Flag the final word of this item.
    if (cnt == 2'd2) begin
      r1.last_result = 1'b1;
    end else if (cnt == 2'd1) begin
      r0.last_result = 1'b1;
    end
  end

  assign push_o.cnt = cnt;
  assign push_o.r0  = r0;
  assign push_o.r1  = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      quote_q    <= 1'b0;
      star_q     <= 1'b0;
      shape_q    <= SHAPE_NONE;
      cur_line_q <= POS_ONE;
      cur_col_q  <= POS_ONE;
      tok_line_q <= POS_ONE;
      tok_col_q  <= POS_ONE;
    end else begin
      mode_q     <= mode_d;
      quote_q    <= quote_d;
      star_q     <= star_d;
      shape_q    <= shape_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      tok_line_q <= tok_line_d;
      tok_col_q  <= tok_col_d;
    end
  end

endmodule

FILE: design/sexp_fifo.sv
module sexp_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  sexp_pkg::push_t push_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            valid_o,
  output sexp_pkg::res_t  head_o
);
  import sexp_pkg::*;

  localparam int DEPTH = 4;

  res_t       entry_q [DEPTH];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] count_q, count_d;
  logic [1:0] wr_next;

  assign wr_next = wr_q + 2'd1;
  assign valid_o = (count_q != 3'd0);
  // Room must remain for the two words an item can produce.
  assign full_o  = (count_q > 3'd2);
  assign head_o  = entry_q[rd_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_d    = wr_q + push_i.cnt;
    rd_d    = pop_i ? rd_q + 2'd1 : rd_q;
    count_d = count_q + {1'b0, push_i.cnt} - {2'b00, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  // Result storage; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) entry_q[wr_q] <= push_i.r0;
    if (push_i.cnt == 2'd2) entry_q[wr_next] <= push_i.r1;
  end

endmodule
